/* src/m3i_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_pkg: shared types and constants
// Element format, pipeline widths and item types of the 3x3 inverse core.
// ----------------------------------------------------------------------------
package m3i_pkg;

  localparam int ELEMENT_WIDTH = 32;
  localparam int FRACTION_BITS = 16;
  localparam int COF_WIDTH     = 2 * ELEMENT_WIDTH + 1;
  localparam int DET_WIDTH     = 3 * ELEMENT_WIDTH + 2;
  localparam int QUO_BITS      = ELEMENT_WIDTH + 1;
  localparam int NUM_WIDTH     = COF_WIDTH + 2 * FRACTION_BITS;
  localparam int THR_WIDTH     = 32;
  localparam int FIFO_DEPTH    = 2;
  localparam int THR_RESET     = 1;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_SINGULAR  = 2'd1,
    STATUS_SATURATED = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [ELEMENT_WIDTH-1:0] m00;
    logic signed [ELEMENT_WIDTH-1:0] m01;
    logic signed [ELEMENT_WIDTH-1:0] m02;
    logic signed [ELEMENT_WIDTH-1:0] m10;
    logic signed [ELEMENT_WIDTH-1:0] m11;
    logic signed [ELEMENT_WIDTH-1:0] m12;
    logic signed [ELEMENT_WIDTH-1:0] m20;
    logic signed [ELEMENT_WIDTH-1:0] m21;
    logic signed [ELEMENT_WIDTH-1:0] m22;
  } matrix_t;

  typedef struct packed {
    logic signed [ELEMENT_WIDTH-1:0] inv00;
    logic signed [ELEMENT_WIDTH-1:0] inv01;
    logic signed [ELEMENT_WIDTH-1:0] inv02;
    logic signed [ELEMENT_WIDTH-1:0] inv10;
    logic signed [ELEMENT_WIDTH-1:0] inv11;
    logic signed [ELEMENT_WIDTH-1:0] inv12;
    logic signed [ELEMENT_WIDTH-1:0] inv20;
    logic signed [ELEMENT_WIDTH-1:0] inv21;
    logic signed [ELEMENT_WIDTH-1:0] inv22;
    status_e                         status;
  } result_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [8:0][COF_WIDTH-1:0] cof;
    logic [DET_WIDTH-1:0]      adet;
    logic                      det_neg;
    logic                      singular;
  } job_t;

endpackage
`default_nettype wire

/* src/m3i_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_front: cofactor and determinant pipeline
// Forms the adjugate and the exact determinant, classifies the item as
// singular or invertible against the threshold register.
// ----------------------------------------------------------------------------
module m3i_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire m3i_pkg::matrix_t  matrix_i,
  input  wire logic              cfg_valid_i,
  input  wire logic [31:0]       cfg_data_i,
  output logic                   job_valid_o,
  output m3i_pkg::job_t          job_o
);

  localparam int W   = m3i_pkg::ELEMENT_WIDTH;
  localparam int F   = m3i_pkg::FRACTION_BITS;
  localparam int CW  = m3i_pkg::COF_WIDTH;
  localparam int DW  = m3i_pkg::DET_WIDTH;
  localparam int TW  = m3i_pkg::THR_WIDTH;
  localparam int ShR = (3 * F >= TW) ? 3 * F - TW : 0;
  localparam int ShL = (3 * F <  TW) ? TW - 3 * F : 0;

  logic [TW-1:0]          thr_q;
  logic [5:0]             vld_q;
  logic signed [W-1:0]    m_in [3][3];
  logic signed [W-1:0]    m_q  [3][3];
  logic signed [2*W-1:0]  pa_q [3][3];
  logic signed [2*W-1:0]  pb_q [3][3];
  logic signed [W-1:0]    r1_q [3];
  logic signed [W-1:0]    r2_q [3];
  logic signed [CW-1:0]   cof2_q [3][3];
  logic signed [CW-1:0]   cof3_q [3][3];
  logic signed [CW-1:0]   cof4_q [3][3];
  logic signed [2*W:0]    lo_q [3];
  logic signed [2*W:0]    hi_q [3];
  logic signed [DW-1:0]   det_q;
  logic [DW-1:0]          adet;
  logic [DW+TW-1:0]       scaled;
  m3i_pkg::job_t          job_q;

  always_comb begin
    m_in[0][0] = matrix_i.m00; m_in[0][1] = matrix_i.m01; m_in[0][2] = matrix_i.m02;
    m_in[1][0] = matrix_i.m10; m_in[1][1] = matrix_i.m11; m_in[1][2] = matrix_i.m12;
    m_in[2][0] = matrix_i.m20; m_in[2][1] = matrix_i.m21; m_in[2][2] = matrix_i.m22;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= TW'(m3i_pkg::THR_RESET);
      vld_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_comb begin
    adet   = det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
    scaled = ({{TW{1'b0}}, adet} >> ShR) << ShL;
  end

  always_ff @(posedge clk_i) begin
    m_q <= m_in;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pa_q[i][j] <= m_q[(j+1)%3][(i+1)%3] * m_q[(j+2)%3][(i+2)%3];
        pb_q[i][j] <= m_q[(j+1)%3][(i+2)%3] * m_q[(j+2)%3][(i+1)%3];
        cof2_q[i][j] <= CW'(pa_q[i][j]) - CW'(pb_q[i][j]);
      end
    end
    r1_q <= m_q[0];
    r2_q <= r1_q;
    cof3_q <= cof2_q;
    cof4_q <= cof3_q;
    for (int j = 0; j < 3; j++) begin
      lo_q[j] <= r2_q[j] * $signed({1'b0, cof2_q[j][0][W-1:0]});
      hi_q[j] <= r2_q[j] * $signed(cof2_q[j][0][CW-1:W]);
    end
    det_q <= DW'(lo_q[0]) + DW'(lo_q[1]) + DW'(lo_q[2])
           + ((DW'(hi_q[0]) + DW'(hi_q[1]) + DW'(hi_q[2])) <<< W);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        job_q.cof[i*3+j] <= cof4_q[i][j];
      end
    end
    job_q.adet     <= adet;
    job_q.det_neg  <= det_q[DW-1];
    job_q.singular <= (det_q == '0) || (scaled < {{DW{1'b0}}, thr_q});
  end

  assign job_valid_o = vld_q[5];
  assign job_o       = job_q;

endmodule
`default_nettype wire

/* src/m3i_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_fifo: item queue between front and back
// Small register queue that decouples classification from division.
// ----------------------------------------------------------------------------
module m3i_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire m3i_pkg::job_t  data_i,
  input  wire logic           pop_i,
  output logic                empty_o,
  output logic                full_o,
  output m3i_pkg::job_t       data_o
);

  localparam int D  = m3i_pkg::FIFO_DEPTH;
  localparam int AW = (D > 1) ? $clog2(D) : 1;

  m3i_pkg::job_t     mem_q [D];
  logic [AW-1:0]     wr_q, rd_q;
  logic [AW:0]       cnt_q;
  logic              do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (AW+1)'(D));
  assign do_pop  = pop_i && !empty_o;
  assign do_push = push_i && (!full_o || do_pop);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == AW'(D - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == AW'(D - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !do_pop))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue underflow");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(D))
    else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

/* src/m3i_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_back: scaling by the reciprocal determinant
// Nine lanes of a pipelined restoring divider, one quotient bit per stage,
// then rounding, saturation and the output register.
// ----------------------------------------------------------------------------
module m3i_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  wire m3i_pkg::job_t  job_i,
  output logic                valid_o,
  output m3i_pkg::result_t    result_o
);

  localparam int W  = m3i_pkg::ELEMENT_WIDTH;
  localparam int F  = m3i_pkg::FRACTION_BITS;
  localparam int CW = m3i_pkg::COF_WIDTH;
  localparam int DW = m3i_pkg::DET_WIDTH;
  localparam int QB = m3i_pkg::QUO_BITS;
  localparam int NW = m3i_pkg::NUM_WIDTH;
  localparam logic [QB:0] LimPos = {3'b000, {(W-1){1'b1}}};
  localparam logic [QB:0] LimNeg = {3'b001, {(W-1){1'b0}}};

  logic [DW-1:0]  rem_q  [QB+1][9];
  logic [QB-1:0]  quo_q  [QB+1][9];
  logic [QB-1:0]  low_q  [QB+1][9];
  logic           neg_q  [QB+1][9];
  logic           satp_q [QB+1][9];
  logic [DW-1:0]  adet_q [QB+1];
  logic           sing_q [QB+1];
  logic [QB:0]    vld_q;

  logic [CW-1:0]  craw [9];
  logic [CW-1:0]  mag  [9];
  logic [NW-1:0]  num  [9];

  m3i_pkg::result_t res_q;
  logic             done_q;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      craw[k] = job_i.cof[k];
      mag[k]  = craw[k][CW-1] ? (~craw[k] + 1'b1) : craw[k];
      num[k]  = {mag[k], {(2*F){1'b0}}};
    end
  end

  always_ff @(posedge clk_i) begin
    adet_q[0] <= job_i.adet;
    sing_q[0] <= job_i.singular;
    for (int k = 0; k < 9; k++) begin
      rem_q[0][k]  <= DW'(num[k][NW-1:QB]);
      satp_q[0][k] <= DW'(num[k][NW-1:QB]) >= job_i.adet;
      low_q[0][k]  <= num[k][QB-1:0];
      quo_q[0][k]  <= '0;
      neg_q[0][k]  <= craw[k][CW-1] ^ job_i.det_neg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QB-1:0], valid_i};
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_stage
    logic [DW:0]   r2   [9];
    logic [DW+1:0] diff [9];

    always_comb begin
      for (int k = 0; k < 9; k++) begin
        r2[k]   = {rem_q[s][k], low_q[s][k][QB-1]};
        diff[k] = {1'b0, r2[k]} - {2'b00, adet_q[s]};
      end
    end

    always_ff @(posedge clk_i) begin
      adet_q[s+1] <= adet_q[s];
      sing_q[s+1] <= sing_q[s];
      for (int k = 0; k < 9; k++) begin
        rem_q[s+1][k]  <= diff[k][DW+1] ? r2[k][DW-1:0] : diff[k][DW-1:0];
        quo_q[s+1][k]  <= {quo_q[s][k][QB-2:0], !diff[k][DW+1]};
        low_q[s+1][k]  <= low_q[s][k] << 1;
        neg_q[s+1][k]  <= neg_q[s][k];
        satp_q[s+1][k] <= satp_q[s][k];
      end
    end
  end

  logic [QB:0]   qr  [9];
  logic [QB:0]   qm  [9];
  logic          sat [9];
  logic [W-1:0]  val [9];
  logic          any_sat;
  m3i_pkg::result_t res_d;

  always_comb begin
    any_sat = 1'b0;
    for (int k = 0; k < 9; k++) begin
      qr[k]  = {1'b0, quo_q[QB][k]}
             + (QB+1)'({rem_q[QB][k], 1'b0} >= {1'b0, adet_q[QB]});
      sat[k] = satp_q[QB][k] || (neg_q[QB][k] ? (qr[k] > LimNeg) : (qr[k] > LimPos));
      qm[k]  = sat[k] ? (neg_q[QB][k] ? LimNeg : LimPos) : qr[k];
      val[k] = neg_q[QB][k] ? (~qm[k][W-1:0] + 1'b1) : qm[k][W-1:0];
      if (sing_q[QB]) begin
        val[k] = '0;
      end
      any_sat = any_sat | sat[k];
    end
    res_d.inv00 = val[0]; res_d.inv01 = val[1]; res_d.inv02 = val[2];
    res_d.inv10 = val[3]; res_d.inv11 = val[4]; res_d.inv12 = val[5];
    res_d.inv20 = val[6]; res_d.inv21 = val[7]; res_d.inv22 = val[8];
    priority if (sing_q[QB]) begin
      res_d.status = m3i_pkg::STATUS_SINGULAR;
    end else if (any_sat) begin
      res_d.status = m3i_pkg::STATUS_SATURATED;
    end else begin
      res_d.status = m3i_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[QB];
    end
  end

  assign valid_o  = done_q;
  assign result_o = res_q;

`ifndef SYNTHESIS
  a_done_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(vld_q[QB]))
    else $error("result without item in divider");
  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_q.status == m3i_pkg::STATUS_SINGULAR) |->
      (res_q.inv00 == '0 && res_q.inv11 == '0 && res_q.inv22 == '0))
    else $error("singular result not cleared");
  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (res_q.status == m3i_pkg::STATUS_OK ||
                res_q.status == m3i_pkg::STATUS_SINGULAR ||
                res_q.status == m3i_pkg::STATUS_SATURATED))
    else $error("illegal status code");
`endif

endmodule
`default_nettype wire

/* src/matrix3_inverse_adjugate_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix3_inverse_adjugate_core: 3x3 Q16.16 matrix inverse
// Exact adjugate and determinant, rounded division, saturation.
// ----------------------------------------------------------------------------
// Usage:
//   Drive matrix_i and raise start; the item is taken on an edge where busy
//   is low. busy only rises if the internal queue fills, which the free
//   running divider prevents, so one matrix may enter every cycle.
//   Each item yields one result on result_o, flagged by result_valid_o for
//   exactly one cycle, in input order. The divider resolves one quotient bit
//   per stage over ELEMENT_WIDTH + 1 stages, behind six front stages and the
//   queue. Throughput is one item per cycle.
//   The receiver cannot stall; results must be captured when flagged.
//   singular_threshold is written on cfg_valid_i (cfg_ready_o is always
//   high). The user must write it only while no item is in flight; the
//   block itself does not enforce it. Reset sets it to 1.
//   Reset clears all valid flags and the queue; no results follow reset.
// ----------------------------------------------------------------------------
module matrix3_inverse_adjugate_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire m3i_pkg::matrix_t  matrix_i,
  output logic                   result_valid_o,
  output m3i_pkg::result_t       result_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [31:0]       cfg_data_i
);

  logic           f_valid, q_empty, q_full;
  m3i_pkg::job_t  f_job, q_job;

  assign cfg_ready_o = 1'b1;
  assign busy        = q_full;

  m3i_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (start && !busy),
    .matrix_i    (matrix_i),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .job_valid_o (f_valid),
    .job_o       (f_job)
  );

  m3i_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .data_i  (f_job),
    .pop_i   (!q_empty),
    .empty_o (q_empty),
    .full_o  (q_full),
    .data_o  (q_job)
  );

  m3i_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (!q_empty),
    .job_i    (q_job),
    .valid_o  (result_valid_o),
    .result_o (result_o)
  );

endmodule
`default_nettype wire

/* tb/matrix3_inverse_adjugate_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3_inverse_adjugate_core_test: self-checking bench for the 3x3 inverse
// Directed corner matrices, then random matrices of several shapes under a
// range of singular thresholds. Every result is checked against an exact
// wide-integer adjugate predictor; random start gaps, one result per item.
// ----------------------------------------------------------------------------
module matrix3_inverse_adjugate_core_test;

  typedef logic signed [191:0] wide_t;

  localparam wide_t LIM_POS = 192'sd2147483647;
  localparam wide_t LIM_NEG = 192'sd2147483648;
  localparam int    ONE     = 32'h0001_0000;
  localparam int    DRAIN   = 60;
  localparam int    WATCHDOG_LIMIT = 4000;
  localparam int    PHASE_ITEMS    = 90;

  typedef struct {
    m3i_pkg::matrix_t m;
    logic             checked;
    m3i_pkg::result_t inv;
  } directed_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  m3i_pkg::matrix_t matrix_i = '0;
  logic             result_valid_o;
  m3i_pkg::result_t result_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [31:0]      cfg_data_i = '0;

  m3i_pkg::result_t pending_inverses[$];
  logic [31:0]      threshold = m3i_pkg::THR_RESET;
  int               errors = 0;
  int               idle_cycles = 0;
  logic             item_taken = 1'b0;

  matrix3_inverse_adjugate_core i_dut (
    .clk_i, .rst_ni, .start, .busy, .matrix_i, .result_valid_o, .result_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  function automatic wide_t widen(input logic [31:0] v);
    return {{160{v[31]}}, v};
  endfunction

  function automatic m3i_pkg::result_t predict_inverse(input m3i_pkg::matrix_t mx,
                                                       input logic [31:0] thr);
    wide_t            e[3][3];
    wide_t            cof[3][3];
    wide_t            det, adet, num, quo, rem;
    logic [31:0]      val[9];
    logic             neg, sat, singular;
    int               r1, r2, c1, c2;
    m3i_pkg::result_t r;
    e[0][0] = widen(mx.m00); e[0][1] = widen(mx.m01); e[0][2] = widen(mx.m02);
    e[1][0] = widen(mx.m10); e[1][1] = widen(mx.m11); e[1][2] = widen(mx.m12);
    e[2][0] = widen(mx.m20); e[2][1] = widen(mx.m21); e[2][2] = widen(mx.m22);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        r1 = (j + 1) % 3; r2 = (j + 2) % 3; c1 = (i + 1) % 3; c2 = (i + 2) % 3;
        cof[i][j] = e[r1][c1] * e[r2][c2] - e[r1][c2] * e[r2][c1];
      end
    end
    det = e[0][0] * cof[0][0] + e[0][1] * cof[1][0] + e[0][2] * cof[2][0];
    adet = det[191] ? -det : det;
    singular = (det == 0) || ((adet >>> 16) < {160'b0, thr});
    sat = 1'b0;
    for (int k = 0; k < 9; k++) begin
      val[k] = '0;
      if (!singular) begin
        num = cof[k / 3][k % 3];
        neg = num[191] ^ det[191];
        num = (num[191] ? -num : num) <<< 32;
        quo = num / adet;
        rem = num % adet;
        if ((rem <<< 1) >= adet) quo = quo + 1;
        if (!neg && quo > LIM_POS) begin
          quo = LIM_POS; sat = 1'b1;
        end
        if (neg && quo > LIM_NEG) begin
          quo = LIM_NEG; sat = 1'b1;
        end
        val[k] = neg ? -quo[31:0] : quo[31:0];
      end
    end
    r = {val[0], val[1], val[2], val[3], val[4], val[5], val[6], val[7], val[8], 2'b00};
    r.status = singular ? m3i_pkg::STATUS_SINGULAR
             : (sat ? m3i_pkg::STATUS_SATURATED : m3i_pkg::STATUS_OK);
    return r;
  endfunction

  function automatic m3i_pkg::matrix_t diag(input logic [31:0] a, b, c);
    m3i_pkg::matrix_t mx;
    mx = '0;
    mx.m00 = a; mx.m11 = b; mx.m22 = c;
    return mx;
  endfunction

  function automatic m3i_pkg::result_t diag_inv(input logic [31:0] a, b, c,
                                                input m3i_pkg::status_e st);
    m3i_pkg::result_t r;
    r = '0;
    r.inv00 = a; r.inv11 = b; r.inv22 = c; r.status = st;
    return r;
  endfunction

  function automatic logic [31:0] rand_elem(input int shape);
    case (shape)
      0: return $urandom;
      1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      2: return $urandom_range(0, 64) - 32;
      default: return $urandom_range(0, 32'h0000_1000) - 32'h0000_0800;
    endcase
  endfunction

  function automatic m3i_pkg::matrix_t rand_matrix();
    m3i_pkg::matrix_t mx;
    logic [31:0]      v[9];
    int               shape;
    shape = $urandom_range(0, 9);
    for (int k = 0; k < 9; k++) v[k] = rand_elem(shape < 2 ? 0 : (shape < 5 ? 1 : 3));
    case (shape)
      5, 6: begin
        v[0] = v[0] + 4 * ONE; v[4] = v[4] - 3 * ONE; v[8] = v[8] + ONE;
      end
      7: for (int k = 0; k < 3; k++) v[6 + k] = v[k];
      8: for (int k = 0; k < 9; k++) v[k] = rand_elem(2);
      9: begin
        for (int k = 0; k < 9; k++) v[k] = (k % 4 == 0) ? ONE : 32'h0;
        v[$urandom_range(0, 8)] = $urandom;
        v[8] = rand_elem(2);
      end
      default: ;
    endcase
    mx = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]};
    return mx;
  endfunction

  task automatic send_matrix(input m3i_pkg::matrix_t mx, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    matrix_i <= mx;
    do @(posedge clk_i); while (busy);
    pending_inverses.push_back(predict_inverse(mx, threshold));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_inverses.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [31:0] thr);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= thr;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    threshold = thr;
  endtask

  always @(posedge clk_i) begin
    item_taken <= (start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o);
    if (result_valid_o) begin
      if (pending_inverses.size() == 0) begin
        $error("unexpected result %h", result_o);
        errors++;
      end else begin
        m3i_pkg::result_t want;
        want = pending_inverses.pop_front();
        for (int k = 0; k < 9; k++) begin
          if (want[2 + 32 * (8 - k) +: 32] !== result_o[2 + 32 * (8 - k) +: 32]) begin
            $error("inv%0d%0d expected %h actual %h", k / 3, k % 3,
                   want[2 + 32 * (8 - k) +: 32], result_o[2 + 32 * (8 - k) +: 32]);
            errors++;
          end
        end
        if (want.status !== result_o.status) begin
          $error("status expected %0d actual %0d", want.status, result_o.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    idle_cycles <= item_taken ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("matrix3_inverse_adjugate_core_test NOT OK");
      $finish;
    end
  end

  initial begin
    directed_row_t    rows[$];
    logic [31:0]      thr_list[5];
    m3i_pkg::matrix_t mx;
    rows.push_back('{diag(ONE, ONE, ONE), 1'b1,
                     diag_inv(ONE, ONE, ONE, m3i_pkg::STATUS_OK)});
    rows.push_back('{'0, 1'b1, diag_inv(0, 0, 0, m3i_pkg::STATUS_SINGULAR)});
    rows.push_back('{'1, 1'b1, diag_inv(0, 0, 0, m3i_pkg::STATUS_SINGULAR)});
    rows.push_back('{diag(2 * ONE, 2 * ONE, 2 * ONE), 1'b1,
                     diag_inv(ONE / 2, ONE / 2, ONE / 2, m3i_pkg::STATUS_OK)});
    rows.push_back('{diag(32'h1, 32'h1, 32'h1), 1'b1,
                     diag_inv(0, 0, 0, m3i_pkg::STATUS_SINGULAR)});
    rows.push_back('{diag(ONE, ONE, 32'h1), 1'b1,
                     diag_inv(ONE, ONE, 32'h7FFF_FFFF, m3i_pkg::STATUS_SATURATED)});
    rows.push_back('{diag(ONE, ONE, 32'hFFFF_FFFF), 1'b1,
                     diag_inv(ONE, ONE, 32'h8000_0000, m3i_pkg::STATUS_SATURATED)});
    rows.push_back('{diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1'b0, '0});
    rows.push_back('{diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b0, '0});
    rows.push_back('{diag(32'h100, 32'h100, 32'h100), 1'b0, '0});
    rows.push_back('{diag(3 * ONE, 3 * ONE, 3 * ONE), 1'b0, '0});
    rows.push_back('{diag(ONE, 32'hFFFF_0000, 7 * ONE), 1'b0, '0});
    mx = {ONE, 2 * ONE, 3 * ONE, 32'h0, ONE, 4 * ONE, 5 * ONE, 6 * ONE, 32'h0};
    rows.push_back('{mx, 1'b0, '0});
    mx = {32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1,
          32'h1, 32'h0, 32'hFFFF_FFFF};
    rows.push_back('{mx, 1'b0, '0});
    mx = {32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
          32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF};
    rows.push_back('{mx, 1'b0, '0});

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[n]) begin
      if (rows[n].checked && predict_inverse(rows[n].m, threshold) !== rows[n].inv) begin
        $error("table row %0d disagrees with predictor", n);
        errors++;
      end
      send_matrix(rows[n].m, n % 3);
    end

    thr_list = '{32'h0, 32'hFFFF_FFFF, 32'h0001_0000, $urandom, 32'h1};
    foreach (thr_list[p]) begin
      write_threshold(thr_list[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) wait_drained();
        send_matrix(rand_matrix(), (n % 30 < 10) ? 0 : $urandom_range(0, 8));
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("matrix3_inverse_adjugate_core_test OK");
    end else begin
      $display("matrix3_inverse_adjugate_core_test NOT OK");
    end
    $finish;
  end

endmodule
